/* hw/rtl/m3i_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_pkg: shared constants for the 3x3 matrix inverse
// Word format defaults and the cofactor operand table.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // adjugate element k = e[a]*e[b] - e[c]*e[d], elements row-major
  typedef logic [3:0] cof_sel_t [0:8][0:3];

  localparam cof_sel_t COF_SEL = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd5, 4'd1, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

endpackage
`default_nettype wire

/* hw/rtl/matrix3_inverse.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_inverse: 3x3 fixed-point matrix inverse by the adjugate
// Nine cofactor lanes, three determinant lanes and nine divide lanes.
// ----------------------------------------------------------------------------
// Usage:
//   Source channel: src_valid / src_stall carry one matrix word, m00..m22,
//   signed fixed point, row-major. A word is taken when src_valid is high
//   and src_stall is low.
//   Result channel: dst_valid / dst_stall carry r00..r22 plus singular and
//   overflow. The word is taken when dst_valid is high and dst_stall is low.
//   The path has two cofactor stages, three determinant stages, one divide
//   setup stage, WORD_BITS + 1 restoring divide stages (one quotient bit
//   each) and the output register.
//   One matrix per cycle when not frozen; all lanes are fully pipelined.
//   When the result waits under dst_stall the whole pipeline freezes and
//   src_stall is raised; bubbles stay in place.
//   Reset (rst, synchronous) clears only the valid bits; no matrix survives.
//   A zero determinant gives all-zero elements with singular set.
// ----------------------------------------------------------------------------
module matrix3_inverse #(
  parameter int WORD_BITS = m3i_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        src_valid,
  output logic                             src_stall,
  input  wire logic signed [WORD_BITS-1:0] m00,
  input  wire logic signed [WORD_BITS-1:0] m01,
  input  wire logic signed [WORD_BITS-1:0] m02,
  input  wire logic signed [WORD_BITS-1:0] m10,
  input  wire logic signed [WORD_BITS-1:0] m11,
  input  wire logic signed [WORD_BITS-1:0] m12,
  input  wire logic signed [WORD_BITS-1:0] m20,
  input  wire logic signed [WORD_BITS-1:0] m21,
  input  wire logic signed [WORD_BITS-1:0] m22,
  output logic                             dst_valid,
  input  wire logic                        dst_stall,
  output logic signed [WORD_BITS-1:0]      r00,
  output logic signed [WORD_BITS-1:0]      r01,
  output logic signed [WORD_BITS-1:0]      r02,
  output logic signed [WORD_BITS-1:0]      r10,
  output logic signed [WORD_BITS-1:0]      r11,
  output logic signed [WORD_BITS-1:0]      r12,
  output logic signed [WORD_BITS-1:0]      r20,
  output logic signed [WORD_BITS-1:0]      r21,
  output logic signed [WORD_BITS-1:0]      r22,
  output logic                             singular,
  output logic                             overflow
);
  import m3i_pkg::*;

  localparam int LAT = WORD_BITS + 8;
  localparam int CW  = 2*WORD_BITS + 1;
  localparam int DW  = 3*WORD_BITS + 3;
  localparam int ZN  = WORD_BITS + 2;

  logic           en;
  logic [LAT-1:0] vld;

  // pipeline moves unless the finished word is held by the receiver
  assign en        = !(vld[LAT-1] && dst_stall);
  assign src_stall = !en;
  assign dst_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], src_valid};
    end
  end

  logic signed [WORD_BITS-1:0] mv [0:8];

  assign mv[0] = m00;
  assign mv[1] = m01;
  assign mv[2] = m02;
  assign mv[3] = m10;
  assign mv[4] = m11;
  assign mv[5] = m12;
  assign mv[6] = m20;
  assign mv[7] = m21;
  assign mv[8] = m22;

  // cofactor lanes: adjugate registered after the product stage
  logic signed [CW-1:0] adj   [0:8];
  logic signed [CW-1:0] adj_d [0:8][0:2];

  for (genvar k = 0; k < 9; k++) begin : g_cof
    m3i_cof #(.WORD_BITS(WORD_BITS)) u_cof (
      .clk (clk),
      .en  (en),
      .a   (mv[COF_SEL[k][0]]),
      .b   (mv[COF_SEL[k][1]]),
      .c   (mv[COF_SEL[k][2]]),
      .d   (mv[COF_SEL[k][3]]),
      .adj (adj[k])
    );

    // hold the adjugate until the determinant is ready
    always_ff @(posedge clk) begin
      if (en) begin
        adj_d[k][0] <= adj[k];
        adj_d[k][1] <= adj_d[k][0];
        adj_d[k][2] <= adj_d[k][1];
      end
    end
  end

  // row 0 delayed to meet the first adjugate column
  logic signed [WORD_BITS-1:0] e1 [0:2];
  logic signed [WORD_BITS-1:0] e2 [0:2];
  logic signed [3*WORD_BITS:0] term [0:2];

  for (genvar j = 0; j < 3; j++) begin : g_term
    always_ff @(posedge clk) begin
      if (en) begin
        e1[j] <= mv[j];
        e2[j] <= e1[j];
      end
    end

    m3i_term #(.WORD_BITS(WORD_BITS)) u_term (
      .clk  (clk),
      .en   (en),
      .e    (e2[j]),
      .adj  (adj[3*j]),
      .term (term[j])
    );
  end

  logic signed [DW-1:0] det;

  always_ff @(posedge clk) begin
    if (en) begin
      det <= $signed({{2{term[0][3*WORD_BITS]}}, term[0]})
           + $signed({{2{term[1][3*WORD_BITS]}}, term[1]})
           + $signed({{2{term[2][3*WORD_BITS]}}, term[2]});
    end
  end

  // singular flag rides alongside the divide stages
  logic zp [0:ZN-1];

  always_ff @(posedge clk) begin
    if (en) begin
      zp[0] <= (det == '0);
      for (int i = 1; i < ZN; i++) begin
        zp[i] <= zp[i-1];
      end
    end
  end

  logic [WORD_BITS-1:0] res [0:8];
  logic [8:0]           sat;

  for (genvar k = 0; k < 9; k++) begin : g_div
    m3i_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .adj (adj_d[k][2]),
      .det (det),
      .res (res[k]),
      .sat (sat[k])
    );
  end

  // merge: output word register
  logic [WORD_BITS-1:0] rr [0:8];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        rr[k] <= zp[ZN-1] ? '0 : res[k];
      end
      singular <= zp[ZN-1];
      overflow <= !zp[ZN-1] && (|sat);
    end
  end

  assign r00 = rr[0];
  assign r01 = rr[1];
  assign r02 = rr[2];
  assign r10 = rr[3];
  assign r11 = rr[4];
  assign r12 = rr[5];
  assign r20 = rr[6];
  assign r21 = rr[7];
  assign r22 = rr[8];

endmodule
`default_nettype wire

/* hw/rtl/m3i_cof.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_cof: cofactor lane
// Two products in the first stage, their exact difference in the second.
// ----------------------------------------------------------------------------
module m3i_cof #(
  parameter int WORD_BITS = m3i_pkg::WORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [WORD_BITS-1:0] a,
  input  wire logic signed [WORD_BITS-1:0] b,
  input  wire logic signed [WORD_BITS-1:0] c,
  input  wire logic signed [WORD_BITS-1:0] d,
  output logic signed [2*WORD_BITS:0]      adj
);
  import m3i_pkg::*;

  logic signed [2*WORD_BITS-1:0] p;
  logic signed [2*WORD_BITS-1:0] s;

  always_ff @(posedge clk) begin
    if (en) begin
      p   <= a * b;
      s   <= c * d;
      adj <= $signed({p[2*WORD_BITS-1], p}) - $signed({s[2*WORD_BITS-1], s});
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/m3i_term.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_term: determinant term lane
// Element times adjugate entry, split into two narrow partial products.
// ----------------------------------------------------------------------------
module m3i_term #(
  parameter int WORD_BITS = m3i_pkg::WORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [WORD_BITS-1:0] e,
  input  wire logic signed [2*WORD_BITS:0] adj,
  output logic signed [3*WORD_BITS:0]      term
);
  import m3i_pkg::*;

  logic signed [WORD_BITS:0]   lo;
  logic signed [WORD_BITS:0]   hi;
  logic signed [2*WORD_BITS:0] pl;
  logic signed [2*WORD_BITS:0] ph;

  // low half taken unsigned, high half keeps the sign
  assign lo = $signed({1'b0, adj[WORD_BITS-1:0]});
  assign hi = adj[2*WORD_BITS:WORD_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      pl   <= e * lo;
      ph   <= e * hi;
      term <= $signed({ph, {WORD_BITS{1'b0}}}) + $signed({{WORD_BITS{pl[2*WORD_BITS]}}, pl});
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/m3i_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_div: divide lane
// Rounded adjugate/determinant quotient, one quotient bit per stage, saturated.
// ----------------------------------------------------------------------------
module m3i_div #(
  parameter int WORD_BITS = m3i_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [2*WORD_BITS:0]   adj,
  input  wire logic signed [3*WORD_BITS+2:0] det,
  output logic        [WORD_BITS-1:0]        res,
  output logic                               sat
);
  import m3i_pkg::*;

  localparam int CW  = 2*WORD_BITS + 1;
  localparam int DW  = 3*WORD_BITS + 3;
  localparam int NA  = CW + 2*FRAC_BITS + 1;
  localparam int NW  = ((NA > DW) ? NA : DW) + 1;
  localparam int XA  = DW + 1 + WORD_BITS;
  localparam int XW  = (XA > NW) ? XA : NW;
  localparam int NS  = WORD_BITS + 1;

  logic [CW-1:0] cmag;
  logic [DW-1:0] dmag;

  assign cmag = adj[CW-1] ? CW'(-adj) : CW'(adj);
  assign dmag = det[DW-1] ? DW'(-det) : DW'(det);

  logic [NW-1:0]    rem [0:NS];
  logic [DW:0]      dn  [0:NS];
  logic [WORD_BITS:0] qq [0:NS];
  logic             ng  [0:NS];

  // numerator 2|C|*2^(2F) + |D|, denominator 2|D|: round to nearest, ties away
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= NW'({cmag, {(2*FRAC_BITS+1){1'b0}}}) + NW'(dmag);
      dn[0]  <= {dmag, 1'b0};
      qq[0]  <= '0;
      ng[0]  <= adj[CW-1] ^ det[DW-1];
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic [XW-1:0] sh;
    logic [XW-1:0] diff;
    logic          ge;

    assign sh   = XW'(dn[i]) << (WORD_BITS - i);
    assign ge   = XW'(rem[i]) >= sh;
    assign diff = XW'(rem[i]) - sh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? diff[NW-1:0] : rem[i];
        qq[i+1]  <= qq[i] | ((WORD_BITS+1)'(ge) << (WORD_BITS - i));
        dn[i+1]  <= dn[i];
        ng[i+1]  <= ng[i];
      end
    end
  end

  logic [WORD_BITS:0]   lim;
  logic [WORD_BITS-1:0] mag;

  always_comb begin
    lim = ((WORD_BITS+1)'(1) << (WORD_BITS - 1)) - (WORD_BITS+1)'(!ng[NS]);
    sat = qq[NS] > lim;
    mag = sat ? lim[WORD_BITS-1:0] : qq[NS][WORD_BITS-1:0];
    res = ng[NS] ? -mag : mag;
  end

endmodule
`default_nettype wire

/* tb/sv/tb_matrix3_inverse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix3_inverse: self-checking bench for the 3x3 fixed-point inverse
// Streams matrices through the block under random idling on both sides and
// checks every result word against an exact adjugate/determinant predictor.
// ----------------------------------------------------------------------------
module tb_matrix3_inverse;

  localparam int W = m3i_pkg::WORD_BITS_DEF;
  localparam int F = m3i_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = W + 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1000;

  typedef logic signed [W-1:0] elem_t;
  typedef elem_t mat_t [0:8];

  typedef struct {
    elem_t r [0:8];
    logic  singular;
    logic  overflow;
  } inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  elem_t m [0:8];
  logic dst_valid;
  logic dst_stall = 1'b0;
  elem_t r [0:8];
  logic singular, overflow;

  mat_t     pending_mats [$];
  inverse_t expected_inv [$];
  int       errors = 0;
  bit       sender_quiet = 1'b0;   // idling off for a stretch
  bit       receiver_quiet = 1'b0;
  int       hold_req = 0;          // long receiver hold-off, in cycles
  bit       flush_pause = 1'b0;    // sender waits until all results came

  initial for (int k = 0; k < 9; k++) m[k] = '0;

  always #10 clk = ~clk;

  matrix3_inverse u_dut (
    .clk(clk), .rst(rst), .src_valid(src_valid), .src_stall(src_stall),
    .m00(m[0]), .m01(m[1]), .m02(m[2]), .m10(m[3]), .m11(m[4]), .m12(m[5]),
    .m20(m[6]), .m21(m[7]), .m22(m[8]),
    .dst_valid(dst_valid), .dst_stall(dst_stall),
    .r00(r[0]), .r01(r[1]), .r02(r[2]), .r10(r[3]), .r11(r[4]), .r12(r[5]),
    .r20(r[6]), .r21(r[7]), .r22(r[8]),
    .singular(singular), .overflow(overflow)
  );

  // Exact predictor: cofactors are 2W+1 bits, determinant 3W+3 bits, so
  // 256-bit signed arithmetic holds every intermediate with room to spare.
  function automatic inverse_t invert_matrix(mat_t a);
    logic signed [255:0] e [0:8];
    logic signed [255:0] adj [0:8];
    logic signed [255:0] det, num, den, q, lim;
    logic neg;
    inverse_t res;
    for (int k = 0; k < 9; k++) e[k] = a[k];
    for (int k = 0; k < 9; k++)
      adj[k] = e[m3i_pkg::COF_SEL[k][0]] * e[m3i_pkg::COF_SEL[k][1]]
             - e[m3i_pkg::COF_SEL[k][2]] * e[m3i_pkg::COF_SEL[k][3]];
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    res.singular = (det == 0);
    res.overflow = 1'b0;
    for (int k = 0; k < 9; k++) res.r[k] = '0;
    if (det != 0) begin
      den = (det < 0) ? -det : det;
      for (int k = 0; k < 9; k++) begin
        neg = (adj[k] < 0) ^ (det < 0);
        num = (adj[k] < 0) ? -adj[k] : adj[k];
        // round half away from zero on magnitudes
        q = ((num <<< (2 * F + 1)) + den) / (den <<< 1);
        lim = (256'sd1 <<< (W - 1)) - (neg ? 0 : 1);
        if (q > lim) begin
          q = lim;
          res.overflow = 1'b1;
        end
        res.r[k] = neg ? elem_t'(-q) : elem_t'(q);
      end
    end
    return res;
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 9))
      0: return elem_t'($urandom);
      1: return elem_t'({$urandom} >> $urandom_range(0, 31));
      2: return {1'b1, {(W-1){1'b0}}};
      3: return {1'b0, {(W-1){1'b1}}};
      4: return '0;
      default: return elem_t'($signed($urandom_range(0, 8 << F)) - (4 << F));
    endcase
  endfunction

  // Driver: next word is offered only after the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else if (!src_valid || !src_stall) begin
      if (pending_mats.size() != 0 && !flush_pause &&
          (sender_quiet || $urandom_range(0, 99) >= 22)) begin
        src_valid <= 1'b1;
        for (int k = 0; k < 9; k++) m[k] <= pending_mats[0][k];
        expected_inv.push_back(invert_matrix(pending_mats[0]));
        void'(pending_mats.pop_front());
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // Receiver stall and result check
  always @(posedge clk) begin
    inverse_t exp_w;
    if (!rst && dst_valid && !dst_stall) begin
      if (expected_inv.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_w = expected_inv.pop_front();
        for (int k = 0; k < 9; k++)
          if (r[k] !== exp_w.r[k]) begin
            $error("r%0d%0d: expected %0d, got %0d", k / 3, k % 3, exp_w.r[k], r[k]);
            errors++;
          end
        if (singular !== exp_w.singular) begin
          $error("singular: expected %0b, got %0b", exp_w.singular, singular);
          errors++;
        end
        if (overflow !== exp_w.overflow) begin
          $error("overflow: expected %0b, got %0b", exp_w.overflow, overflow);
          errors++;
        end
      end
    end
    if (hold_req > 0) begin
      dst_stall <= 1'b1;
      hold_req <= hold_req - 1;
    end else begin
      dst_stall <= !receiver_quiet && ($urandom_range(0, 99) < 22);
    end
  end

  // Watchdog: cycles with no handshake on either side
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((src_valid && !src_stall) || (dst_valid && !dst_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_mat(input elem_t a0, a1, a2, a3, a4, a5, a6, a7, a8);
    mat_t t;
    t = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
    pending_mats.push_back(t);
  endtask

  task automatic wait_drained();
    while (pending_mats.size() != 0 || expected_inv.size() != 0) @(posedge clk);
  endtask

  initial begin
    localparam elem_t ONE = elem_t'(1 << F);
    localparam elem_t MAXV = {1'b0, {(W-1){1'b1}}};
    localparam elem_t MINV = {1'b1, {(W-1){1'b0}}};
    mat_t t;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: identity, scaled, zero, singular, tiny det, extremes
    push_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
    push_mat(2 * ONE, 0, 0, 0, -4 * ONE, 0, 0, 0, ONE / 2);
    push_mat(0, 0, 0, 0, 0, 0, 0, 0, 0);
    push_mat(ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE, 7, 8, 9);
    push_mat(1, 0, 0, 0, 1, 0, 0, 0, 1);          // saturating inverse
    push_mat(-1, 0, 0, 0, 1, 0, 0, 0, -1);
    push_mat(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV);
    push_mat(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV);
    push_mat(MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, 1);
    push_mat(MAXV, MINV, 0, 1, MAXV, MINV, MINV, 1, MAXV);
    push_mat(0, ONE, 0, ONE, 0, 0, 0, 0, ONE);    // permutation
    push_mat(3, 0, 0, 0, 1, 0, 0, 0, 1);          // rounding tie region
    push_mat(-ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE);
    push_mat(elem_t'(32'hAAAAAAAA), elem_t'(32'h55555555), ONE, ONE,
             elem_t'(32'h55555555), elem_t'(32'hAAAAAAAA), 0, ONE, ONE);
    wait_drained();

    // long receiver hold-off while the sender keeps offering: pipeline fills
    sender_quiet = 1'b1;
    hold_req = 3 * LATENCY;
    for (int n = 0; n < 120; n++) begin
      for (int k = 0; k < 9; k++) t[k] = rand_elem();
      pending_mats.push_back(t);
    end
    wait_drained();
    sender_quiet = 1'b0;

    for (int n = 0; n < N_RANDOM; n++) begin
      for (int k = 0; k < 9; k++) t[k] = rand_elem();
      // some singular matrices: repeat a row
      if ($urandom_range(0, 9) == 0)
        for (int k = 0; k < 3; k++) t[6 + k] = t[3 + k];
      pending_mats.push_back(t);
      if (n == 300) begin
        // sender pause until every result is back
        while (pending_mats.size() != 0) @(posedge clk);
        flush_pause = 1'b1;
        while (expected_inv.size() != 0) @(posedge clk);
        flush_pause = 1'b0;
      end
      if (n == 500) begin
        while (pending_mats.size() != 0) @(posedge clk);
        receiver_quiet = 1'b1;
        sender_quiet = 1'b1;
      end
      if (n == 700) begin
        while (pending_mats.size() != 0) @(posedge clk);
        receiver_quiet = 1'b0;
        sender_quiet = 1'b0;
      end
    end
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_inv.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/m3i_pkg.sv
hw/rtl/m3i_cof.sv
hw/rtl/m3i_term.sv
hw/rtl/m3i_div.sv
hw/rtl/matrix3_inverse.sv
tb/sv/tb_matrix3_inverse.sv
